/* rtl/core/sitoa_pkg.sv */
// shared types and constants for the signed integer to decimal text core
// no dependencies
`default_nettype none

package sitoa_pkg;

  // input and digit geometry
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int BCD_W         = 4;
  localparam int NUM_DIGITS    = 10;
  localparam int DIGIT_IDX_W   = 4;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(CONV_STEPS);

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // classified request handed from front to back
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } sitoa_item_t;

  // write side of the queue
  typedef struct packed {
    logic        valid;
    sitoa_item_t item;
  } sitoa_push_t;

  // read side of the queue
  typedef struct packed {
    logic        valid;
    sitoa_item_t item;
  } sitoa_head_t;

endpackage

`default_nettype wire

/* rtl/core/sitoa_front.sv */
// front part: accepts input requests, splits sign and unsigned magnitude
// depends on sitoa_pkg
`default_nettype none

module sitoa_front import sitoa_pkg::*; (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               q_full,
  output sitoa_push_t             push
);

  logic neg;

  // take a request whenever the queue has room
  assign in_ready = !q_full;

  // two's complement magnitude, most negative value stays as its unsigned form
  assign neg            = in_value[VALUE_W-1];
  assign push.valid     = in_valid && !q_full;
  assign push.item.neg  = neg;
  assign push.item.mag  = neg ? (VALUE_W'(0) - in_value) : in_value;

endmodule

`default_nettype wire

/* rtl/core/sitoa_queue.sv */
// short fifo of classified requests between front and back
// depends on sitoa_pkg
`default_nettype none

module sitoa_queue import sitoa_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sitoa_push_t push,
  output logic             full,
  input  wire logic        pop,
  output sitoa_head_t      head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sitoa_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sitoa_back.sv */
// back part: binary to bcd by shift-add-3, four bits a cycle, then emits text
// depends on sitoa_pkg
`default_nettype none

module sitoa_back import sitoa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sitoa_head_t       head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char_code,
  output logic                   out_last_char
);

  localparam int DD_W = NUM_DIGITS * BCD_W + VALUE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                               state_r;
  logic [NUM_DIGITS-1:0][BCD_W-1:0]     bcd_r;
  logic [VALUE_W-1:0]                   bin_r;
  logic                                 neg_r;
  logic [STEP_CNT_W-1:0]                step_r;
  logic [DIGIT_IDX_W-1:0]               idx_r;
  logic                                 out_valid_r;
  logic [CHAR_W-1:0]                    out_char_r;
  logic                                 out_last_r;

  logic [DD_W-1:0]                      dd_nxt;
  logic [NUM_DIGITS-1:0][BCD_W-1:0]     bcd_nxt;
  logic [DIGIT_IDX_W-1:0]               top_nxt;
  logic                                 out_free;
  logic                                 emit;

  // several bits of shift-add-3 per cycle
  function automatic logic [DD_W-1:0] dabble(input logic [DD_W-1:0] d);
    logic [DD_W-1:0]  w;
    logic [BCD_W-1:0] dig;
    w = d;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        dig = w[VALUE_W + k*BCD_W +: BCD_W];
        if (dig >= BCD_W'(5)) begin
          w[VALUE_W + k*BCD_W +: BCD_W] = dig + BCD_W'(3);
        end
      end
      w = w << 1;
    end
    return w;
  endfunction

  assign dd_nxt  = dabble({bcd_r, bin_r});
  assign bcd_nxt = dd_nxt[DD_W-1 -: NUM_DIGITS*BCD_W];

  // highest nonzero digit of the finished bcd word, zero when all clear
  always_comb begin
    top_nxt = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_nxt[k] != '0) begin
        top_nxt = DIGIT_IDX_W'(k);
      end
    end
  end

  assign out_free      = !out_valid_r || out_ready;
  assign emit          = out_free && ((state_r == ST_SIGN) || (state_r == ST_DIGIT));
  assign pop           = (state_r == ST_IDLE) && head.valid;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      idx_r       <= '0;
      neg_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            neg_r   <= head.item.neg;
            bin_r   <= head.item.mag;
            bcd_r   <= '0;
            step_r  <= '0;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_r  <= bcd_nxt;
          bin_r  <= dd_nxt[VALUE_W-1:0];
          step_r <= step_r + 1'b1;
          if (step_r == STEP_CNT_W'(CONV_STEPS - 1)) begin
            idx_r   <= top_nxt;
            state_r <= neg_r ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= CHAR_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= CHAR_ZERO + {{(CHAR_W-BCD_W){1'b0}}, bcd_r[idx_r]};
            out_last_r  <= (idx_r == '0);
            if (idx_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/signed_int_to_decimal_ascii_core.sv */
// top level: signed 32-bit integer to decimal ascii text, 1 to 11 characters a request
// depends on sitoa_pkg, sitoa_front, sitoa_queue, sitoa_back
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_value (32, signed)
//   out     | output    | out_valid / out_ready  | out_char_code (8), out_last_char (1)
//
// a request leaves the queue, passes through the bcd converter (four bits a
// cycle) and then goes out as 1 to 11 characters, one character per cycle
// while the output is not stalled; the back sequencer sets this order.
// the queue takes new requests while the back works, up to its depth.
// reset is synchronous and active low and empties queue and output register.
// a stalled output holds its character; the sequencer waits on it.
`default_nettype none

module signed_int_to_decimal_ascii_core import sitoa_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CHAR_W-1:0]       out_char_code,
  output logic                    out_last_char
);

  sitoa_push_t push;
  sitoa_head_t head;
  logic        q_full;
  logic        pop;

  // classify requests
  sitoa_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .q_full   (q_full),
    .push     (push)
  );

  // decouple front and back
  sitoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head)
  );

  // convert and emit text
  sitoa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

/* bench/signed_int_to_decimal_ascii_core_test.sv */
// testbench for signed_int_to_decimal_ascii_core: random and directed integers,
// characters checked in order against a built-in decimal text predictor
// depends on sitoa_pkg and the core rtl
`timescale 1ns / 100ps
`default_nettype none

module signed_int_to_decimal_ascii_core_test import sitoa_pkg::*;;

  localparam int unsigned RADIX = 10;
  localparam int DRAIN_CYCLES = 40;

  // one expected character, with the number it came from for messages
  typedef struct packed {
    logic [CHAR_W-1:0]  code;
    logic               last;
    logic [VALUE_W-1:0] src;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_char_code;
  logic               out_last_char;

  text_char_t text_q[$];
  int         err_count = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;

  signed_int_to_decimal_ascii_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // clock
  always #10 clk = ~clk;

  // decimal text of one number, appended to the expected characters
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic              neg;
    logic [31:0]       mag;
    logic [BCD_W-1:0]  dig[NUM_DIGITS];
    int                nd;
    text_char_t        c;
    neg = v[VALUE_W-1];
    mag = neg ? (32'd0 - v) : v;
    nd = 0;
    do begin
      dig[nd] = BCD_W'(mag % RADIX);
      mag = mag / RADIX;
      nd++;
    end while (mag != 0 && nd < NUM_DIGITS);
    c.src = v;
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = CHAR_ZERO + CHAR_W'(dig[i]);
      c.last = (i == 0);
      text_q.push_back(c);
    end
  endfunction

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] src,
                                 input int got, input int want);
    $display("mismatch %s: value %0d got %0d want %0d", what, $signed(src), got, want);
    err_count++;
  endtask

  // one request on the input channel, with random idle cycles in front
  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    predict_text(v);
  endtask

  // stop sending until every expected character is out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pow10(input int k);
    logic [VALUE_W-1:0] p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * RADIX;
    return p;
  endfunction

  // mix of full-range values, short numbers, digit-count boundaries and values near the signed extremes
  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    int                 k;
    k = $urandom_range(9, 1);
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom % pow10(k);
      2: v = pow10(k) + $urandom_range(2) - 1;
      default: v = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                     : 32'h8000_0000 + $urandom_range(3);
    endcase
    if ($urandom_range(1) && v != 32'h8000_0000) v = 32'd0 - v;
    return v;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_value(rand_value());
  endtask

  // extremes, zero, sign boundaries and digit-count steps
  task automatic test_extremes();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             -32'sd1000000000, 32'd999999999, 32'h5555_5555, 32'haaaa_aaaa,
             32'd1234567890, -32'sd1234567890, -32'sd9, 32'd2000000000,
             32'd1000000009, 32'd4000000000};
    idle_pct = 0;
    stall_pct = 0;
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    stall_pct = 0;
    run_random(80);
  endtask

  task automatic test_sender_gaps();
    idle_pct = 54;
    stall_pct = 0;
    run_random(80);
  endtask

  task automatic test_receiver_stalls();
    idle_pct = 0;
    stall_pct = 54;
    run_random(80);
  endtask

  // light idling on both sides, with a full drain in the middle
  task automatic test_both_sides_and_drain();
    idle_pct = 8;
    stall_pct = 8;
    run_random(40);
    wait_drained();
    run_random(40);
  endtask

  // receiver ready pattern
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (text_q.size() == 0) begin
        report_mismatch("unexpected char", '0, out_char_code, -1);
      end else begin
        want = text_q.pop_front();
        if (out_char_code !== want.code)
          report_mismatch("char_code", want.src, out_char_code, want.code);
        if (out_last_char !== want.last)
          report_mismatch("last_char", want.src, out_last_char, want.last);
      end
    end
  end

  // main sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_and_drain();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
